// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never hold out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/pedb_pkg.sv =====
// ----------------------------------------------------------------------------
// pedb_pkg
// Types and constants shared by the peak envelope / dB level core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pedb_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int NORM_STEPS  = 6;
    localparam int LOG2_FRAC   = 16;

    // 20*log10(2) in Q.16
    localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;

    localparam logic [15:0]        ATTACK_RESET  = 16'd65000;
    localparam logic [15:0]        RELEASE_RESET = 16'd65500;
    localparam logic signed [15:0] OFFSET_RESET  = 16'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_OFFSET  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        attack_coef;
        logic [15:0]        release_coef;
        logic signed [15:0] level_offset;
    } t_cfg;

    typedef struct packed {
        logic [31:0] envelope;
        logic        frame_end;
    } t_qentry;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DONE
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_SQR,
        B_MUL,
        B_FIN
    } t_back_state;

endpackage

// ===== rtl/core/pedb_front.sv =====
// ----------------------------------------------------------------------------
// pedb_front
// Rectifies each sample and runs the attack/release envelope recurrence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pedb_front #(
    parameter int SAMPLE_BITS    = pedb_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = pedb_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pedb_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    output logic                          o_push,
    output pedb_pkg::t_qentry             o_entry,
    input  logic                          i_q_full
);
    import pedb_pkg::*;

    localparam int CW  = COEF_FRAC_BITS + 1;
    localparam int CXW = (CW > 16) ? CW : 16;
    localparam int PW  = CW + 32;

    t_front_state r_state, n_state;

    logic [31:0]    r_env;
    logic [31:0]    r_big;
    logic [31:0]    r_opnd;
    logic [CW-1:0]  r_coef;
    logic           r_attack;
    logic           r_fe;
    logic [PW-1:0]  r_prod;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] mag;
    logic [47:0]            big48;
    logic [31:0]            big;
    logic                   attack;
    logic [CXW-1:0]         coef_x, one_x, coef_c;
    logic [PW-1:0]          acc;
    logic [31:0]            new_env;

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        mag    = i_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - $unsigned(i_sample))
                                         : $unsigned(i_sample);
        big48  = 48'(mag) << 16;
        big    = (big48[47:32] != '0) ? 32'hFFFF_FFFF : big48[31:0];
        attack = (big >= r_env);
        coef_x = attack ? CXW'(i_cfg.attack_coef) : CXW'(i_cfg.release_coef);
        one_x  = CXW'(1) << COEF_FRAC_BITS;
        coef_c = (coef_x > one_x) ? one_x : coef_x;
    end

    // Attack: S*M - a*(M-E) + S/2, which equals a*E + (S-a)*M + S/2.
    always_comb begin
        acc = ({1'b0, r_big, {COEF_FRAC_BITS{1'b0}}} + (PW'(1) << (COEF_FRAC_BITS - 1)))
              - r_prod;
        if (r_attack) begin
            new_env = acc[COEF_FRAC_BITS+31:COEF_FRAC_BITS];
        end else begin
            new_env = r_prod[COEF_FRAC_BITS+31:COEF_FRAC_BITS];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_MUL;
            end
            F_MUL: begin
                n_state = F_DONE;
            end
            F_DONE: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        o_push     = (r_state == F_DONE) && !i_q_full;
        o_entry.envelope  = new_env;
        o_entry.frame_end = r_fe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            if (o_push) r_env <= new_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_big    <= big;
            r_attack <= attack;
            r_coef   <= coef_c[CW-1:0];
            r_opnd   <= attack ? (big - r_env) : r_env;
            r_fe     <= i_frame_end;
        end
        if (r_state == F_MUL) begin
            r_prod <= PW'(r_coef) * PW'(r_opnd);
        end
    end

endmodule

// ===== rtl/core/pedb_queue.sv =====
// ----------------------------------------------------------------------------
// pedb_queue
// Short register queue between the envelope front and the dB back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pedb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pedb_pkg::t_qentry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output pedb_pkg::t_qentry o_entry,
    output logic              o_empty
);
    import pedb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qentry          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

endmodule

// ===== rtl/core/pedb_back.sv =====
// ----------------------------------------------------------------------------
// pedb_back
// Iterative log2 of the envelope, scaling to dB, offset and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pedb_back #(
    parameter int SAMPLE_BITS = pedb_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pedb_pkg::t_cfg     i_cfg,
    input  pedb_pkg::t_qentry  i_entry,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_envelope,
    output logic signed [15:0] o_level_db,
    output logic               o_frame_end_out
);
    import pedb_pkg::*;

    // Full scale plus the Q16.16 point, in Q.16
    localparam logic signed [23:0] LOG_BIAS = 24'((SAMPLE_BITS + 15) << LOG2_FRAC);

    t_back_state r_state, n_state;

    logic [31:0]        r_env;
    logic               r_fe;
    logic [63:0]        r_w;
    logic [5:0]         r_z;
    logic [2:0]         r_step;
    logic [3:0]         r_sq_cnt;
    logic [30:0]        r_m;
    logic [5:0]         r_n;
    logic [15:0]        r_frac;
    logic signed [43:0] r_prod;
    logic               r_out_valid;
    logic [31:0]        r_out_env;
    logic signed [15:0] r_out_db;
    logic               r_out_fe;

    logic               out_load;
    logic [6:0]         shamt;
    logic [63:0]        mask;
    logic               hit;
    logic [63:0]        n_w;
    logic [5:0]         n_z;
    logic [61:0]        sq;
    logic [31:0]        sq_top;
    logic signed [23:0] diff;
    logic signed [43:0] rnd;
    logic signed [19:0] q;
    logic signed [20:0] sum;
    logic signed [15:0] db_sat;

    // Normaliser: one binary step per cycle, 32, 16, ... 1 bits.
    always_comb begin
        shamt = 7'd32 >> r_step;
        mask  = ~({64{1'b1}} >> shamt);
        hit   = ((r_w & mask) == '0);
        n_w   = hit ? (r_w << shamt) : r_w;
        n_z   = r_z + (hit ? shamt[5:0] : 6'd0);
    end

    always_comb begin
        sq     = 62'(r_m) * 62'(r_m);
        sq_top = sq[61:30];
        diff   = $signed({2'b00, r_n, r_frac}) - LOG_BIAS;
        rnd    = r_prod + 44'sd8388608;
        q      = rnd[43:24];
        sum    = $signed({q[19], q}) + $signed({{5{i_cfg.level_offset[15]}},
                                                i_cfg.level_offset});
        if (sum > 21'sd32767) begin
            db_sat = 16'sh7FFF;
        end else if (sum < -21'sd32768) begin
            db_sat = 16'sh8000;
        end else begin
            db_sat = sum[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) n_state = B_NORM;
            end
            B_NORM: begin
                if (r_step == 3'(NORM_STEPS - 1)) n_state = B_SQR;
            end
            B_SQR: begin
                if (r_sq_cnt == 4'(LOG2_FRAC - 1)) n_state = B_MUL;
            end
            B_MUL: begin
                n_state = B_FIN;
            end
            B_FIN: begin
                if (!r_out_valid || !i_out_stall) n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = (r_state == B_IDLE) && !i_q_empty;
        out_load = (r_state == B_FIN) && (!r_out_valid || !i_out_stall);
    end

    assign o_out_valid     = r_out_valid;
    assign o_envelope      = r_out_env;
    assign o_level_db      = r_out_db;
    assign o_frame_end_out = r_out_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_env  <= i_entry.envelope;
                r_fe   <= i_entry.frame_end;
                r_w    <= {31'd0, 33'(i_entry.envelope) + 33'd1};
                r_z    <= '0;
                r_step <= '0;
            end
            B_NORM: begin
                r_w      <= n_w;
                r_z      <= n_z;
                r_step   <= r_step + 1'b1;
                r_m      <= n_w[63:33];
                r_n      <= 6'd63 - n_z;
                r_sq_cnt <= '0;
                r_frac   <= '0;
            end
            B_SQR: begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
                r_frac   <= {r_frac[14:0], sq_top[31]};
                r_m      <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            end
            B_MUL: begin
                r_prod <= diff * DB_PER_OCTAVE;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_env <= r_env;
            r_out_db  <= db_sat;
            r_out_fe  <= r_fe;
        end
    end

endmodule

// ===== rtl/core/peak_envelope_to_db.sv =====
// ----------------------------------------------------------------------------
// peak_envelope_to_db
// Peak envelope follower with attack/release smoothing and a level in dB.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one signed sample and a
//   frame end mark per item. Output channel: o_out_valid / i_out_stall carry
//   the new Q16.16 envelope, the Q8.8 level and the frame end copy.
//   Configuration: i_cfg_valid / o_cfg_ready write attack (0), release (1)
//   or level offset (2); other indexes are dropped. Write only while idle.
//   Pacing: set by the log2 unit in the back end, which takes a new item
//   only once done with the last (1 load, 6 normalise steps, 16 squaring
//   rounds on one 31x31 multiplier, 1 dB scaling multiply, 1 saturate).
//   The envelope front holds one item at a time and runs ahead through a
//   two-item queue.
//   Reset: envelope cleared to zero, coefficients to their defaults, queue
//   and output register emptied.
//   Stall: a held result keeps its output register; the back end waits in
//   its final step, the queue fills, then the input channel stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module peak_envelope_to_db #(
    parameter int SAMPLE_BITS    = pedb_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = pedb_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pedb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    // sample input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_frame_end,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [31:0]                       o_envelope,
    output logic signed [15:0]                o_level_db,
    output logic                              o_frame_end_out
);
    import pedb_pkg::*;

    t_cfg    r_cfg;
    t_qentry push_entry, pop_entry;
    logic    q_push, q_full, q_pop, q_empty;

    // Register file: always ready, so a write lands on the handshake edge.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coef  <= ATTACK_RESET;
            r_cfg.release_coef <= RELEASE_RESET;
            r_cfg.level_offset <= OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ATTACK:  r_cfg.attack_coef  <= i_cfg_data;
                CFG_RELEASE: r_cfg.release_coef <= i_cfg_data;
                CFG_OFFSET:  r_cfg.level_offset <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Front: rectify, compare with the envelope, one multiply-add update.
    pedb_front #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_frame_end (i_frame_end),
        .o_push      (q_push),
        .o_entry     (push_entry),
        .i_q_full    (q_full)
    );

    // Decoupling queue: envelope and frame end per item.
    pedb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (pop_entry),
        .o_empty (q_empty)
    );

    // Back: log2, dB scaling, offset, saturation and the output register.
    pedb_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_entry         (pop_entry),
        .i_q_empty       (q_empty),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_envelope      (o_envelope),
        .o_level_db      (o_level_db),
        .o_frame_end_out (o_frame_end_out)
    );

    // The front never overruns the queue, the back never reads it empty.
    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, q_push && q_full, "push into full queue")
    `ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, q_pop && q_empty, "pop from empty queue")
    // The front holds one item at a time: an accepted item blocks the next.
    `ASSERT_CLK(a_front_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "front busy")

endmodule

// ===== tb/pedb_checker.sv =====
// ----------------------------------------------------------------------------
// pedb_checker
// Watches the register, sample and result channels of the peak envelope
// core. Keeps its own envelope and register copies, works out the envelope
// and dB level for every accepted item and compares them with the results
// in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pedb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pedb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [15:0]             i_sample,
    input  logic                           i_frame_end,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [31:0]                    i_envelope,
    input  logic signed [15:0]             i_level_db,
    input  logic                           i_frame_end_out,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import pedb_pkg::*;

    localparam logic [63:0] COEF_ONE = 64'd1 << COEF_FRAC_BITS_DEF;
    // log2 of full scale in Q.16: sample full scale times the Q16.16 unit
    localparam longint FULL_SCALE_LOG2 = longint'(SAMPLE_BITS_DEF - 1 + 16) << LOG2_FRAC;

    typedef struct {
        logic [31:0]        env;
        logic signed [15:0] db;
        logic               fe;
    } t_level_result;

    t_level_result      level_queue[$];
    logic [31:0]        env_state;
    logic [15:0]        attack_q;
    logic [15:0]        release_q;
    logic signed [15:0] offset_q;

    // log2 in Q.16, fraction by repeated squaring of a Q1.30 mantissa
    function automatic logic [31:0] log2_fix(input logic [32:0] v);
        int          msb;
        int          k;
        logic [63:0] m;
        logic [15:0] frac;
        msb = 0;
        for (k = 1; k <= 32; k++)
            if (v[k]) msb = k;
        m = 64'(v);
        if (msb >= 30) m = m >> (msb - 30);
        else           m = m << (30 - msb);
        frac = '0;
        for (k = 0; k < LOG2_FRAC; k++) begin
            m    = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {msb[15:0], frac};
    endfunction

    function automatic logic signed [15:0] level_of_env(input logic [31:0] env);
        longint diff;
        longint prod;
        longint sum;
        diff = longint'(log2_fix({1'b0, env} + 33'd1)) - FULL_SCALE_LOG2;
        prod = diff * longint'(DB_PER_OCTAVE) + (longint'(1) << 23);
        // Q.32 down to Q8.8, half rounds up: arithmetic shift floors
        sum  = (prod >>> 24) + longint'(offset_q);
        if (sum > 32767)  sum = 32767;
        if (sum < -32768) sum = -32768;
        return 16'(sum);
    endfunction

    // 16-bit coefficients never exceed one, so no clamp is needed here
    function automatic logic [31:0] next_env(input logic signed [15:0] s,
                                             input logic [31:0] env);
        logic [63:0] mag;
        logic [63:0] big;
        logic [63:0] acc;
        mag = (s < 0) ? 64'(-longint'(s)) : 64'(s);
        big = mag << 16;
        if (big >= 64'(env))
            acc = (64'(attack_q) * 64'(env) + (COEF_ONE - 64'(attack_q)) * big
                   + (COEF_ONE >> 1)) >> COEF_FRAC_BITS_DEF;
        else
            acc = (64'(release_q) * 64'(env)) >> COEF_FRAC_BITS_DEF;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        return acc[31:0];
    endfunction

    assign o_pending = level_queue.size();

    always @(posedge i_clk) begin
        t_level_result exp_r;
        t_level_result new_r;
        int            err_now;
        err_now = 0;
        if (!i_rst_n) begin
            env_state <= '0;
            attack_q  <= ATTACK_RESET;
            release_q <= RELEASE_RESET;
            offset_q  <= OFFSET_RESET;
            level_queue.delete();
            o_errors  <= 0;
            o_checked <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked <= o_checked + 1;
                if (level_queue.size() == 0) begin
                    $display("%0t unexpected result: envelope %0d level %0d",
                             $time, i_envelope, i_level_db);
                    err_now++;
                end else begin
                    exp_r = level_queue.pop_front();
                    if (i_envelope !== exp_r.env) begin
                        $display("%0t envelope mismatch: expected %0d, got %0d",
                                 $time, exp_r.env, i_envelope);
                        err_now++;
                    end
                    if (i_level_db !== exp_r.db) begin
                        $display("%0t level_db mismatch: expected %0d, got %0d",
                                 $time, exp_r.db, i_level_db);
                        err_now++;
                    end
                    if (i_frame_end_out !== exp_r.fe) begin
                        $display("%0t frame_end_out mismatch: expected %0b, got %0b",
                                 $time, exp_r.fe, i_frame_end_out);
                        err_now++;
                    end
                end
            end
            o_errors <= o_errors + err_now;
            if (i_in_valid && !i_in_stall) begin
                new_r.env = next_env(i_sample, env_state);
                new_r.db  = level_of_env(new_r.env);
                new_r.fe  = i_frame_end;
                env_state <= new_r.env;
                level_queue.push_back(new_r);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ATTACK:  attack_q  <= i_cfg_data;
                    CFG_RELEASE: release_q <= i_cfg_data;
                    CFG_OFFSET:  offset_q  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the peak envelope / dB level core. A directed
// run covers silence, full-scale samples of both signs, instant and frozen
// attack and release, and both offset extremes; random phases then feed
// bursts of loud and quiet audio under several register settings, with
// random gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pedb_pkg::*;

    // index with no register behind it: the write must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_WAIT      = 11;
    localparam int SETTLE_CYCLES = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_sample;
    logic               i_frame_end;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [31:0]        o_envelope;
    logic signed [15:0] o_level_db;
    logic               o_frame_end_out;

    int  chk_errors;
    int  chk_pending;
    int  chk_checked;
    int  cycles;
    int  samples_sent;
    int  reg_writes;
    int  settings_run;
    // when set, neither side inserts gaps or stalls
    bit  no_gaps;

    peak_envelope_to_db u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_envelope      (o_envelope),
        .o_level_db      (o_level_db),
        .o_frame_end_out (o_frame_end_out)
    );

    pedb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_frame_end     (i_frame_end),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_envelope      (o_envelope),
        .i_level_db      (o_level_db),
        .i_frame_end_out (o_frame_end_out),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending),
        .o_checked       (chk_checked)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends here
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, chk_pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side. For each result draw a stall length; stall is held for
    // that length (whether or not a result is waiting, so the stall
    // lands on any phase of the back end), then dropped until one is taken.
    initial begin
        int wait_cycles;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            i_out_stall = (wait_cycles != 0);
            repeat (wait_cycles) @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the write.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        reg_writes++;
    endtask

    // Registers may only change once every result is out. Valid drops
    // first so the last sample is not taken a second time while waiting.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    // Called at a falling edge. Valid is left high after acceptance so a
    // back-to-back item keeps it high; a gap lowers it once.
    task automatic send_sample(input logic signed [15:0] s, input logic fe);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample    = s;
        i_frame_end = fe;
        i_in_valid  = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    initial begin
        logic [15:0]        atk;
        logic [15:0]        rel;
        logic signed [15:0] ofs;
        int                 amp;
        int                 seg_left;
        int                 kind;
        logic signed [15:0] s;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ATTACK;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        i_frame_end  = 1'b0;
        no_gaps      = 1'b0;
        samples_sent = 0;
        reg_writes   = 0;
        settings_run = 1;
        amp          = 0;
        seg_left     = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- reset coefficients ---
        // silence from a zero envelope: level of one LSB, saturated low
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        // full-scale attack, both signs, most negative value included
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        // decay through the release coefficient
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd16384, 1'b0);
        send_sample(-16'sd16384, 1'b1);

        // --- instant attack, instant release, top offset ---
        wait_drained();
        write_reg(CFG_ATTACK, 16'd0);
        write_reg(CFG_RELEASE, 16'd0);
        write_reg(CFG_OFFSET, 16'sd32767);
        // dropped write: must leave all three registers alone
        write_reg(CFG_UNUSED, 16'hFFFF);
        settings_run++;
        send_sample(-16'sd32768, 1'b0);   // full scale plus offset: saturates high
        send_sample(16'sd0, 1'b0);        // envelope straight back to zero
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd32768, 1'b0);

        // --- frozen envelope: coefficients at their largest, lowest offset ---
        wait_drained();
        write_reg(CFG_ATTACK, 16'd65535);
        write_reg(CFG_RELEASE, 16'd65535);
        write_reg(CFG_OFFSET, -16'sd32768);
        write_reg(CFG_UNUSED, 16'h0000);
        settings_run++;
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd32768, 1'b1);

        // --- random phases: audio-like bursts under random settings ---
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0:       atk = 16'd0;
                1:       atk = 16'd65535;
                2:       atk = 16'($urandom_range(0, 65535));
                default: atk = 16'($urandom_range(60000, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       rel = 16'd0;
                1:       rel = 16'd65535;
                2:       rel = 16'($urandom_range(0, 65535));
                default: rel = 16'($urandom_range(60000, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       ofs = -16'sd32768;
                1:       ofs = 16'sd32767;
                default: ofs = 16'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_ATTACK, atk);
            write_reg(CFG_RELEASE, rel);
            write_reg(CFG_OFFSET, ofs);
            settings_run++;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // switch between idling and flat-out stretches
                if (n % 25 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                // one hold-off mid-run: let the pipeline empty completely
                if (p == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                // new loudness segment: loud, moderate, quiet or silent
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       amp = 32767;
                        1:       amp = $urandom_range(0, 32767);
                        2:       amp = $urandom_range(0, 255);
                        default: amp = 0;
                    endcase
                end
                seg_left--;
                kind = $urandom_range(0, 9);
                case (kind)
                    0:       s = 16'($urandom_range(0, 65535));
                    1:       s = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                    2:       s = 16'sd0;
                    default: s = 16'(int'($urandom_range(0, 2 * amp)) - amp);
                endcase
                send_sample(s, ($urandom_range(0, 7) == 0));
            end
        end
        no_gaps = 1'b0;

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        // catch anything the core emits after the last expected result
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Run covered %0d samples and %0d register writes over %0d settings,",
                 samples_sent, reg_writes, settings_run);
        $display("%0d results compared in %0d cycles.", chk_checked, cycles);
        if (chk_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
